/* rtl/lpg_pkg.sv */
// Shared constants, codes and types of the line pixel generator.
package lpg_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int ADDR_BITS_DEF  = 48;
   localparam int COORD_MAX      = 16;
   localparam int DEC_MAX        = COORD_MAX + 3;

   localparam int DIM_W       = 13;
   localparam int PITCH_W     = 16;
   localparam int BPP_W       = 3;
   localparam int BASE_W      = 48;
   localparam int COLOUR_W    = 32;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIM_W-1:0]   FB_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0]   FB_HEIGHT_RST = 13'd480;
   localparam logic [PITCH_W-1:0] PITCH_RST     = 16'd2560;
   localparam logic [BPP_W-1:0]   BPP_RST       = 3'd4;
   localparam logic [BASE_W-1:0]  BASE_RST      = 48'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FB_WIDTH  = 3'd0,
      CSR_FB_HEIGHT = 3'd1,
      CSR_PITCH     = 3'd2,
      CSR_BPP       = 3'd3,
      CSR_BASE      = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [DIM_W-1:0]   fb_width;
      logic [DIM_W-1:0]   fb_height;
      logic [PITCH_W-1:0] line_pitch;
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic [BASE_W-1:0]  base_address;
   } cfg_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [COORD_MAX-1:0] x;
      logic [COORD_MAX-1:0] y;
      logic [COORD_MAX-1:0] major;
      logic [COORD_MAX-1:0] minor;
      logic [DEC_MAX-1:0]   decision;
      logic                 x_step;
      logic                 x_neg;
      logic                 y_step;
      logic                 y_neg;
      logic                 swapped;
      logic [COLOUR_W-1:0]  colour;
   } cmd_type;

endpackage

/* rtl/lpg_channels.sv */
// Request and response channel interfaces of the line pixel generator.
interface lpg_req_if #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) ();
   import lpg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;
   logic [COLOUR_W-1:0]   line_colour;

   modport source (output valid, opcode, start_x, start_y, end_x, end_y, line_colour,
                   input ready);
   modport sink (input valid, opcode, start_x, start_y, end_x, end_y, line_colour,
                 output ready);
endinterface

interface lpg_rsp_if #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
   parameter int ADDR_BITS  = lpg_pkg::ADDR_BITS_DEF
) ();
   import lpg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  pixel_valid;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [ADDR_BITS-1:0]  pixel_address;
   logic [COLOUR_W-1:0]   pixel_colour;
   logic                  last_pixel;

   modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                   last_pixel, input ready);
   modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                 last_pixel, output ready);
endinterface

/* rtl/line_pixel_generator.sv */
// Line pixel generator: Bresenham rasterizer producing one framebuffer pixel per transaction.
// A start transaction (opcode 0) clamps both endpoints to the framebuffer and returns the
// first pixel; each step transaction (opcode 1) returns the next pixel with its x, y, byte
// address (base + x*bytes_per_pixel + y*pitch, wrapping at ADDR_BITS) and colour, with
// last_pixel set on the final one; a step while no line is active returns an all-zero
// response. Every request produces exactly one response. Throughput is one transaction per
// clock in both directions while the response side does not stall; a request passes through
// the clamp stage, command queue, stepping stage, multiply stage and address add in turn.
// The front end keeps accepting while the response side stalls until its queue fills.
// Write configuration registers only while no transaction is in flight.
module line_pixel_generator #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
   parameter int ADDR_BITS  = lpg_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [lpg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpg_pkg::CSR_DATA_W-1:0]  csr_write_data,
   lpg_req_if.sink                         req_bus,
   lpg_rsp_if.source                       rsp_bus
);
   import lpg_pkg::*;

   cfg_type cfg;
   cmd_type front_cmd, back_cmd;
   logic    front_valid, front_ready, back_valid, back_ready;

   lpg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_bus   (req_bus),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   lpg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_cmd)
   );

   lpg_back #(.COORD_BITS(COORD_BITS), .ADDR_BITS(ADDR_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (back_valid),
      .cmd       (back_cmd),
      .cmd_ready (back_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* rtl/lpg_csr.sv */
// Configuration registers of the line pixel generator.
module lpg_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [lpg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpg_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output lpg_pkg::cfg_type                cfg
);
   import lpg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FB_WIDTH:  cfg_in.fb_width        = csr_write_data[DIM_W-1:0];
            CSR_FB_HEIGHT: cfg_in.fb_height       = csr_write_data[DIM_W-1:0];
            CSR_PITCH:     cfg_in.line_pitch      = csr_write_data[PITCH_W-1:0];
            CSR_BPP:       cfg_in.bytes_per_pixel = csr_write_data[BPP_W-1:0];
            CSR_BASE:      cfg_in.base_address    = csr_write_data[BASE_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fb_width        <= FB_WIDTH_RST;
         cfg_ff.fb_height       <= FB_HEIGHT_RST;
         cfg_ff.line_pitch      <= PITCH_RST;
         cfg_ff.bytes_per_pixel <= BPP_RST;
         cfg_ff.base_address    <= BASE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/lpg_front.sv */
// Front end: accepts requests, clamps endpoints and sets up line geometry.
module lpg_front #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  lpg_pkg::cfg_type cfg,
   lpg_req_if.sink          req_bus,
   output logic             cmd_valid,
   output lpg_pkg::cmd_type cmd,
   input  logic             cmd_ready
);
   import lpg_pkg::*;

   localparam int CMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
   localparam int DIF_W = COORD_BITS + 1;
   localparam int DEC_W = COORD_BITS + 3;
   localparam logic [CMP_W-1:0] COORD_TOP = CMP_W'((64'd1 << COORD_BITS) - 64'd1);

   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic [COORD_BITS-1:0] c,
      input logic [DIM_W-1:0]      size
   );
      logic [CMP_W-1:0] lim;
      lim = (size == '0) ? '0 : CMP_W'(size - DIM_W'(1));
      if (lim > COORD_TOP) lim = COORD_TOP;
      return (CMP_W'(c) > lim) ? COORD_BITS'(lim) : c;
   endfunction

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_op_ff;
   logic [COORD_BITS-1:0] s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;
   logic [COLOUR_W-1:0]   s1_colour_ff;
   logic                  load;

   logic signed [DIF_W-1:0] dx, dy;
   logic [COORD_BITS-1:0]   adx, ady, major, minor;
   logic                    swapped;
   logic signed [DEC_W-1:0] dec;

   assign req_bus.ready = !s1_valid_ff || cmd_ready;
   assign load          = req_bus.ready;
   assign s1_valid_in   = load ? req_bus.valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_op_ff     <= req_bus.opcode;
         s1_x1_ff     <= clamp_coord(req_bus.start_x, cfg.fb_width);
         s1_y1_ff     <= clamp_coord(req_bus.start_y, cfg.fb_height);
         s1_x2_ff     <= clamp_coord(req_bus.end_x, cfg.fb_width);
         s1_y2_ff     <= clamp_coord(req_bus.end_y, cfg.fb_height);
         s1_colour_ff <= req_bus.line_colour;
      end
   end

   always_comb begin
      dx      = $signed({1'b0, s1_x2_ff}) - $signed({1'b0, s1_x1_ff});
      dy      = $signed({1'b0, s1_y2_ff}) - $signed({1'b0, s1_y1_ff});
      adx     = dx[DIF_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
      ady     = dy[DIF_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
      swapped = ady > adx;
      major   = swapped ? ady : adx;
      minor   = swapped ? adx : ady;
      dec     = $signed(DEC_W'({minor, 1'b0})) - $signed(DEC_W'(major));
   end

   always_comb begin
      cmd.opcode   = opcode_type'(s1_op_ff);
      cmd.x        = COORD_MAX'(s1_x1_ff);
      cmd.y        = COORD_MAX'(s1_y1_ff);
      cmd.major    = COORD_MAX'(major);
      cmd.minor    = COORD_MAX'(minor);
      cmd.decision = DEC_MAX'(dec);
      cmd.x_step   = dx != '0;
      cmd.x_neg    = dx[DIF_W-1];
      cmd.y_step   = dy != '0;
      cmd.y_neg    = dy[DIF_W-1];
      cmd.swapped  = swapped;
      cmd.colour   = s1_colour_ff;
   end

   assign cmd_valid = s1_valid_ff;

endmodule

/* rtl/lpg_queue.sv */
// Command queue between the front end and the pixel back end.
module lpg_queue #(
   parameter int DEPTH = lpg_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  lpg_pkg::cmd_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output lpg_pkg::cmd_type out_data
);
   import lpg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count did not shrink on pop");

endmodule

/* rtl/lpg_back.sv */
// Back end: steps the line, forms pixel addresses and drives the response.
module lpg_back #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
   parameter int ADDR_BITS  = lpg_pkg::ADDR_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  lpg_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  lpg_pkg::cmd_type cmd,
   output logic             cmd_ready,
   lpg_rsp_if.source        rsp_bus
);
   import lpg_pkg::*;

   localparam int DEC_W  = COORD_BITS + 3;
   localparam int PX_W   = COORD_BITS + BPP_W;
   localparam int PY_W   = COORD_BITS + PITCH_W;
   localparam int W1     = (ADDR_BITS > BASE_W) ? ADDR_BITS : BASE_W;
   localparam int WIDE_W = (W1 > PY_W) ? W1 : PY_W;

   logic                    active_ff, active_in;
   logic [COORD_BITS-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [DEC_W-1:0] decision_ff, decision_in;
   logic [COORD_BITS-1:0]   steps_left_ff, steps_left_in;
   logic [COORD_BITS-1:0]   major_ff, major_in, minor_ff, minor_in;
   logic                    x_step_ff, x_step_in, x_neg_ff, x_neg_in;
   logic                    y_step_ff, y_step_in, y_neg_ff, y_neg_in;
   logic                    swapped_ff, swapped_in;
   logic [COLOUR_W-1:0]     colour_ff, colour_in;

   logic                    p1_valid_ff, p1_pix_ff, p1_last_ff;
   logic [COORD_BITS-1:0]   p1_x_ff, p1_y_ff;
   logic [COLOUR_W-1:0]     p1_colour_ff;
   logic                    p1_pix_in, p1_last_in;
   logic [COORD_BITS-1:0]   p1_x_in, p1_y_in;
   logic [COLOUR_W-1:0]     p1_colour_in;

   logic                    p2_valid_ff, p2_pix_ff, p2_last_ff;
   logic [COORD_BITS-1:0]   p2_x_ff, p2_y_ff;
   logic [COLOUR_W-1:0]     p2_colour_ff;
   logic [PX_W-1:0]         p2_prod_x_ff;
   logic [PY_W-1:0]         p2_prod_y_ff;

   logic                    out_valid_ff, out_pix_ff, out_last_ff;
   logic [COORD_BITS-1:0]   out_x_ff, out_y_ff;
   logic [ADDR_BITS-1:0]    out_addr_ff;
   logic [COLOUR_W-1:0]     out_colour_ff;
   logic [WIDE_W-1:0]       addr_sum;

   logic                    advance, take;
   logic [COORD_BITS-1:0]   delta_x, delta_y, step_x, step_y, steps_dec;
   logic signed [DEC_W-1:0] twice_minor, twice_major;

   assign advance   = !out_valid_ff || rsp_bus.ready;
   assign cmd_ready = advance;
   assign take      = cmd_valid && advance;

   always_comb begin
      delta_x     = x_step_ff ? (x_neg_ff ? '1 : COORD_BITS'(1)) : '0;
      delta_y     = y_step_ff ? (y_neg_ff ? '1 : COORD_BITS'(1)) : '0;
      step_x      = cur_x_ff + delta_x;
      step_y      = cur_y_ff + delta_y;
      steps_dec   = steps_left_ff - COORD_BITS'(1);
      twice_minor = $signed(DEC_W'({minor_ff, 1'b0}));
      twice_major = $signed(DEC_W'({major_ff, 1'b0}));

      active_in     = active_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      decision_in   = decision_ff;
      steps_left_in = steps_left_ff;
      major_in      = major_ff;
      minor_in      = minor_ff;
      x_step_in     = x_step_ff;
      x_neg_in      = x_neg_ff;
      y_step_in     = y_step_ff;
      y_neg_in      = y_neg_ff;
      swapped_in    = swapped_ff;
      colour_in     = colour_ff;
      p1_pix_in     = 1'b0;
      p1_last_in    = 1'b0;
      p1_x_in       = '0;
      p1_y_in       = '0;
      p1_colour_in  = '0;

      if (cmd.opcode == OP_START) begin
         cur_x_in      = cmd.x[COORD_BITS-1:0];
         cur_y_in      = cmd.y[COORD_BITS-1:0];
         decision_in   = cmd.decision[DEC_W-1:0];
         major_in      = cmd.major[COORD_BITS-1:0];
         minor_in      = cmd.minor[COORD_BITS-1:0];
         steps_left_in = cmd.major[COORD_BITS-1:0];
         x_step_in     = cmd.x_step;
         x_neg_in      = cmd.x_neg;
         y_step_in     = cmd.y_step;
         y_neg_in      = cmd.y_neg;
         swapped_in    = cmd.swapped;
         colour_in     = cmd.colour;
         active_in     = cmd.major[COORD_BITS-1:0] != '0;
         p1_pix_in     = 1'b1;
         p1_last_in    = cmd.major[COORD_BITS-1:0] == '0;
         p1_x_in       = cmd.x[COORD_BITS-1:0];
         p1_y_in       = cmd.y[COORD_BITS-1:0];
         p1_colour_in  = cmd.colour;
      end else if (active_ff) begin
         if (decision_ff < 0) begin
            if (swapped_ff) cur_y_in = step_y;
            else cur_x_in = step_x;
            decision_in = decision_ff + twice_minor;
         end else begin
            cur_x_in    = step_x;
            cur_y_in    = step_y;
            decision_in = decision_ff + twice_minor - twice_major;
         end
         steps_left_in = steps_dec;
         active_in     = steps_dec != '0;
         p1_pix_in     = 1'b1;
         p1_last_in    = steps_dec == '0;
         p1_x_in       = cur_x_in;
         p1_y_in       = cur_y_in;
         p1_colour_in  = colour_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         steps_left_ff <= '0;
      end else if (take) begin
         active_ff     <= active_in;
         steps_left_ff <= steps_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         decision_ff <= decision_in;
         major_ff    <= major_in;
         minor_ff    <= minor_in;
         x_step_ff   <= x_step_in;
         x_neg_ff    <= x_neg_in;
         y_step_ff   <= y_step_in;
         y_neg_ff    <= y_neg_in;
         swapped_ff  <= swapped_in;
         colour_ff   <= colour_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff  <= take;
         p2_valid_ff  <= p1_valid_ff;
         out_valid_ff <= p2_valid_ff;
      end
   end

   assign addr_sum = WIDE_W'(cfg.base_address) + WIDE_W'(p2_prod_x_ff)
                   + WIDE_W'(p2_prod_y_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_pix_ff     <= p1_pix_in;
         p1_last_ff    <= p1_last_in;
         p1_x_ff       <= p1_x_in;
         p1_y_ff       <= p1_y_in;
         p1_colour_ff  <= p1_colour_in;

         p2_pix_ff     <= p1_pix_ff;
         p2_last_ff    <= p1_last_ff;
         p2_x_ff       <= p1_x_ff;
         p2_y_ff       <= p1_y_ff;
         p2_colour_ff  <= p1_colour_ff;
         p2_prod_x_ff  <= PX_W'(p1_x_ff) * PX_W'(cfg.bytes_per_pixel);
         p2_prod_y_ff  <= PY_W'(p1_y_ff) * PY_W'(cfg.line_pitch);

         out_pix_ff    <= p2_pix_ff;
         out_last_ff   <= p2_last_ff;
         out_x_ff      <= p2_x_ff;
         out_y_ff      <= p2_y_ff;
         out_colour_ff <= p2_colour_ff;
         out_addr_ff   <= p2_pix_ff ? addr_sum[ADDR_BITS-1:0] : '0;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.pixel_valid   = out_pix_ff;
   assign rsp_bus.pixel_x       = out_x_ff;
   assign rsp_bus.pixel_y       = out_y_ff;
   assign rsp_bus.pixel_address = out_addr_ff;
   assign rsp_bus.pixel_colour  = out_colour_ff;
   assign rsp_bus.last_pixel    = out_last_ff;

   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> steps_left_ff != '0)
      else $error("line active with no steps left");

   a_idle_result_blank: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_pix_ff |-> !out_last_ff && out_addr_ff == '0)
      else $error("idle step result carries data");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      take && p1_last_in |=> !active_ff)
      else $error("line still active after last pixel");

endmodule
